// File: rtl/ctk_pkg.sv
// Package for the Collatz step ranker: shared types, constants and state codes.
package ctk_pkg;

    // Step counter saturation point.
    localparam logic [15:0] STEP_MAX = 16'hFFFF;

    // Odd values above this limit would overflow 64 bits in 3n+1.
    localparam logic [63:0] ODD_LIMIT = 64'h5555_5555_5555_5554;

    // Result kinds.
    localparam logic KIND_STEP  = 1'b0;
    localparam logic KIND_ENTRY = 1'b1;

    // One request as held in the front queue.
    typedef struct packed {
        logic [31:0] value;
        logic        final_item;
    } t_item;

    // Status of the step unit.
    typedef struct packed {
        logic        done;
        logic        ovf;
        logic [15:0] steps;
    } t_cz_res;

    // Command to the ranked list.
    typedef struct packed {
        logic        insert;
        logic        rotate;
        logic [31:0] value;
        logic [15:0] steps;
    } t_rk_cmd;

    // What the ranked list shows to the controller.
    typedef struct packed {
        logic [31:0] head_value;
        logic [15:0] head_steps;
        logic [15:0] tail_steps;
    } t_rk_view;

    // One result as held in the output register.
    typedef struct packed {
        logic        result_kind;
        logic [3:0]  rank_index;
        logic [31:0] entry_value;
        logic [15:0] step_count;
        logic        admitted;
        logic        overflow;
        logic        last_of_run;
    } t_result;

    // Back end controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_ITEM,
        S_LIST
    } t_state;

endpackage

// File: rtl/ctk_front.sv
// Front end: accepts requests, masks the start value and holds them in a two-entry queue.
module ctk_front
    import ctk_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_start_value,
    input  logic        i_final_item,
    output logic        o_head_valid,
    output t_item       o_head,
    input  logic        i_pop
);

    localparam int QDepth   = 2;
    localparam int UseBits  = (VALUE_BITS < 32) ? VALUE_BITS : 32;
    localparam logic [31:0] ValueMask = 32'((64'd1 << UseBits) - 64'd1);

    t_item       r_item [QDepth];
    logic [0:0]  r_wr_ptr, n_wr_ptr;
    logic [0:0]  r_rd_ptr, n_rd_ptr;
    logic [1:0]  r_count,  n_count;
    logic        w_push;
    t_item       w_in;

    // Only the low value bits take part in the count.
    assign w_in.value      = i_start_value & ValueMask;
    assign w_in.final_item = i_final_item;

    assign o_ready      = (r_count != 2'(QDepth));
    assign w_push       = i_valid && o_ready;
    assign o_head_valid = (r_count != 2'd0);
    assign o_head       = r_item[r_rd_ptr];

    // Pointer and fill count update.
    always_comb begin
        n_wr_ptr = w_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = i_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (w_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (i_pop && !w_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Queue storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_item[r_wr_ptr] <= w_in;
        end
    end

endmodule

// File: rtl/ctk_collatz.sv
// Iterative step unit: one Collatz step per cycle on a 64-bit working value.
module ctk_collatz
    import ctk_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_value,
    output t_cz_res     o_res
);

    logic        r_busy,  n_busy;
    logic [63:0] r_n,     n_n;
    logic [15:0] r_steps, n_steps;
    logic        w_stop;
    logic        w_ovf_hit;

    // The loop ends at one or below, or when the count saturates.
    assign w_stop    = (r_n <= 64'd1) || (r_steps == STEP_MAX);
    assign w_ovf_hit = r_n[0] && (r_n > ODD_LIMIT);

    assign o_res.done  = r_busy && (w_stop || w_ovf_hit);
    assign o_res.ovf   = w_ovf_hit && !w_stop;
    assign o_res.steps = r_steps;

    // Step: odd values become 3n+1, even values are halved.
    always_comb begin
        n_busy  = r_busy;
        n_n     = r_n;
        n_steps = r_steps;
        if (i_start) begin
            n_busy  = 1'b1;
            n_n     = {32'd0, i_value};
            n_steps = '0;
        end else if (r_busy) begin
            if (o_res.done) begin
                n_busy = 1'b0;
            end else begin
                n_n     = r_n[0] ? (r_n + {r_n[62:0], 1'b0} + 64'd1) : {1'b0, r_n[63:1]};
                n_steps = r_steps + 16'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_n     <= '0;
            r_steps <= '0;
        end else begin
            r_busy  <= n_busy;
            r_n     <= n_n;
            r_steps <= n_steps;
        end
    end

endmodule

// File: rtl/ctk_rank.sv
// Ranked list held as a row of cells: sorted insertion and rotation for read-out.
module ctk_rank
    import ctk_pkg::*;
#(
    parameter int LIST_SIZE = 10
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_rk_cmd  i_cmd,
    output t_rk_view o_view
);

    logic [31:0] r_val [LIST_SIZE];
    logic [15:0] r_stp [LIST_SIZE];
    logic [31:0] n_val [LIST_SIZE];
    logic [15:0] n_stp [LIST_SIZE];
    logic [LIST_SIZE-1:0] w_above;

    assign o_view.head_value = r_val[0];
    assign o_view.head_steps = r_stp[0];
    assign o_view.tail_steps = r_stp[LIST_SIZE-1];

    for (genvar g = 0; g < LIST_SIZE; g++) begin : g_cell
        localparam int Nx = (g + 1) % LIST_SIZE;
        logic [31:0] w_pv;
        logic [15:0] w_ps;
        logic        w_pa;

        // The new entry ranks above this cell on steps, then on value.
        assign w_above[g] = (i_cmd.steps > r_stp[g]) ||
                            ((i_cmd.steps == r_stp[g]) && (i_cmd.value > r_val[g]));

        // What the cell above offers when the list shifts down.
        if (g == 0) begin : g_top
            assign w_pv = i_cmd.value;
            assign w_ps = i_cmd.steps;
            assign w_pa = 1'b0;
        end else begin : g_rest
            assign w_pv = r_val[g-1];
            assign w_ps = r_stp[g-1];
            assign w_pa = w_above[g-1];
        end

        // The list is sorted, so cells below the insertion point take their upper neighbour.
        always_comb begin
            n_val[g] = r_val[g];
            n_stp[g] = r_stp[g];
            if (i_cmd.rotate) begin
                n_val[g] = r_val[Nx];
                n_stp[g] = r_stp[Nx];
            end else if (i_cmd.insert && w_above[g]) begin
                n_val[g] = w_pa ? w_pv : i_cmd.value;
                n_stp[g] = w_pa ? w_ps : i_cmd.steps;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LIST_SIZE; i++) begin
                r_val[i] <= '0;
                r_stp[i] <= '0;
            end
        end else begin
            r_val <= n_val;
            r_stp <= n_stp;
        end
    end

endmodule

// File: rtl/collatz_top_k_ranker.sv
// Top level: each request is taken from the front queue, run through the step unit, and its
// step result is registered for output. The step unit does one step per cycle. The back end
// takes no new request until that result, and after a final request all LIST_SIZE ranked
// entries, have been sent; the two-entry front queue keeps taking requests meanwhile.
// Synchronous active-low reset empties the queue, stops the step unit and clears the list.
module collatz_top_k_ranker
    import ctk_pkg::*;
#(
    parameter int LIST_SIZE  = 10,
    parameter int VALUE_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_start_value,
    input  logic        i_final_item,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_result_kind,
    output logic [3:0]  o_rank_index,
    output logic [31:0] o_entry_value,
    output logic [15:0] o_step_count,
    output logic        o_admitted,
    output logic        o_overflow,
    output logic        o_last_of_run
);

    localparam int CntW = $clog2(LIST_SIZE + 1);

    t_state          r_state, n_state;
    logic [CntW-1:0] r_cnt,   n_cnt;
    logic            r_out_valid, n_out_valid;
    t_result         r_out,   n_out;
    logic [31:0]     r_value, n_value;
    logic            r_final, n_final;

    logic     w_q_valid;
    t_item    w_q_head;
    logic     w_pop;
    logic     w_cz_start;
    t_cz_res  w_cz;
    t_rk_cmd  w_rk_cmd;
    t_rk_view w_rk_view;
    logic     w_adm;

    ctk_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_start_value (i_start_value),
        .i_final_item  (i_final_item),
        .o_head_valid  (w_q_valid),
        .o_head        (w_q_head),
        .i_pop         (w_pop)
    );

    ctk_collatz u_collatz (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cz_start),
        .i_value (w_q_head.value),
        .o_res   (w_cz)
    );

    ctk_rank #(
        .LIST_SIZE (LIST_SIZE)
    ) u_rank (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_rk_cmd),
        .o_view  (w_rk_view)
    );

    assign w_adm = !w_cz.ovf && (w_cz.steps > w_rk_view.tail_steps);

    // Back end control: start a count, rank its result, then send the results.
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_value     = r_value;
        n_final     = r_final;
        w_pop       = 1'b0;
        w_cz_start  = 1'b0;
        w_rk_cmd    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_q_valid) begin
                    w_pop      = 1'b1;
                    w_cz_start = 1'b1;
                    n_value    = w_q_head.value;
                    n_final    = w_q_head.final_item;
                    n_state    = S_RUN;
                end
            end
            S_RUN: begin
                if (w_cz.done) begin
                    w_rk_cmd.insert   = w_adm;
                    w_rk_cmd.value    = r_value;
                    w_rk_cmd.steps    = w_cz.steps;
                    n_out.result_kind = KIND_STEP;
                    n_out.rank_index  = '0;
                    n_out.entry_value = r_value;
                    n_out.step_count  = w_cz.steps;
                    n_out.admitted    = w_adm;
                    n_out.overflow    = w_cz.ovf;
                    n_out.last_of_run = !r_final;
                    n_out_valid       = 1'b1;
                    n_state           = S_ITEM;
                end
            end
            S_ITEM: begin
                if (i_ready) begin
                    if (r_final) begin
                        // Head of the list goes out first; rotating brings up the next.
                        w_rk_cmd.rotate   = 1'b1;
                        n_out.result_kind = KIND_ENTRY;
                        n_out.rank_index  = '0;
                        n_out.entry_value = w_rk_view.head_value;
                        n_out.step_count  = w_rk_view.head_steps;
                        n_out.admitted    = 1'b0;
                        n_out.overflow    = 1'b0;
                        n_out.last_of_run = (LIST_SIZE == 1);
                        n_cnt             = CntW'(1);
                        n_state           = S_LIST;
                    end else begin
                        n_out_valid = 1'b0;
                        n_state     = S_IDLE;
                    end
                end
            end
            S_LIST: begin
                if (i_ready) begin
                    if (r_cnt == CntW'(LIST_SIZE)) begin
                        n_out_valid = 1'b0;
                        n_state     = S_IDLE;
                    end else begin
                        w_rk_cmd.rotate   = 1'b1;
                        n_out.result_kind = KIND_ENTRY;
                        n_out.rank_index  = 4'(r_cnt);
                        n_out.entry_value = w_rk_view.head_value;
                        n_out.step_count  = w_rk_view.head_steps;
                        n_out.admitted    = 1'b0;
                        n_out.overflow    = 1'b0;
                        n_out.last_of_run = (r_cnt == CntW'(LIST_SIZE - 1));
                        n_cnt             = r_cnt + CntW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        r_out   <= n_out;
        r_value <= n_value;
        r_final <= n_final;
    end

    assign o_valid       = r_out_valid;
    assign o_result_kind = r_out.result_kind;
    assign o_rank_index  = r_out.rank_index;
    assign o_entry_value = r_out.entry_value;
    assign o_step_count  = r_out.step_count;
    assign o_admitted    = r_out.admitted;
    assign o_overflow    = r_out.overflow;
    assign o_last_of_run = r_out.last_of_run;

    // A result is only shown while the controller is in a sending state.
    a_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_state == S_ITEM || r_state == S_LIST))
        else $error("result shown outside a sending state");

    // The step unit finishes only while the controller waits for it.
    a_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cz.done |-> (r_state == S_RUN))
        else $error("step unit finished while not awaited");

    // An admitted request never overflowed and is always a step result.
    a_adm_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_admitted) |-> (!o_overflow && o_result_kind == KIND_STEP))
        else $error("admitted flag on an overflowed or list result");

    // A list entry follows only a step result or another list entry.
    a_list_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == S_LIST) |-> $past(r_state == S_ITEM && r_final))
        else $error("list read-out started without a final request");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the Collatz step ranker: directed and random requests.
module tb_top
    import ctk_pkg::*;
;

    localparam int LIST_LEN        = 10;
    localparam int VAL_BITS        = 32;
    localparam int RANDOM_REQUESTS = 460;
    localparam int CYCLE_LIMIT     = 3_000_000;
    localparam int DRAIN_CYCLES    = 32;
    localparam logic [63:0] VALUE_MASK = (64'd1 << VAL_BITS) - 64'd1;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [31:0] i_start_value;
    logic        i_final_item;
    logic        o_valid;
    logic        i_ready;
    logic        o_result_kind;
    logic [3:0]  o_rank_index;
    logic [31:0] o_entry_value;
    logic [15:0] o_step_count;
    logic        o_admitted;
    logic        o_overflow;
    logic        o_last_of_run;

    // Local copy of the ranked list, best entry first.
    logic [31:0] board_values [LIST_LEN];
    logic [15:0] board_steps  [LIST_LEN];

    // Results still owed by the block, oldest first.
    t_result pending_results [$];

    int  mismatches   = 0;
    int  results_seen = 0;
    int  sent         = 0;
    int  finals       = 0;
    bit  quiet        = 1'b0;

    collatz_top_k_ranker #(
        .LIST_SIZE  (LIST_LEN),
        .VALUE_BITS (VAL_BITS)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_start_value (i_start_value),
        .i_final_item  (i_final_item),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_result_kind (o_result_kind),
        .o_rank_index  (o_rank_index),
        .o_entry_value (o_entry_value),
        .o_step_count  (o_step_count),
        .o_admitted    (o_admitted),
        .o_overflow    (o_overflow),
        .o_last_of_run (o_last_of_run)
    );

    // Free-running 10 ns clock.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Idle length for either side: mostly none or short, occasionally long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) begin
            return 0;
        end else if (r < 88) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Collatz iteration on a 64-bit working value, with saturation and overflow stop.
    function automatic void count_steps(input logic [31:0] start, output logic [15:0] steps,
                                        output logic ovf);
        logic [63:0] n;
        int unsigned cnt;
        n   = 64'(start) & VALUE_MASK;
        cnt = 0;
        ovf = 1'b0;
        while (n > 64'd1 && cnt < STEP_MAX) begin
            if (n[0]) begin
                if (n > ODD_LIMIT) begin
                    ovf = 1'b1;
                    break;
                end
                n = 64'd3 * n + 64'd1;
            end else begin
                n = n >> 1;
            end
            cnt++;
        end
        steps = 16'(cnt);
    endfunction

    // Ordering of the list: more steps first, then the larger number.
    function automatic bit ranks_above(logic [15:0] sa, logic [31:0] va,
                                       logic [15:0] sb, logic [31:0] vb);
        if (sa != sb) begin
            return sa > sb;
        end
        return va > vb;
    endfunction

    // Update the local list for one accepted request and queue the results it causes.
    function automatic void rank_request(input logic [31:0] value, input logic fin);
        logic [31:0] start;
        logic [15:0] steps;
        logic        ovf;
        logic        adm;
        logic [31:0] tv;
        logic [15:0] ts;
        t_result     r;
        int          j;
        start = value & 32'(VALUE_MASK);
        count_steps(start, steps, ovf);
        adm = !ovf && (steps > board_steps[LIST_LEN-1]);
        if (adm) begin
            board_values[LIST_LEN-1] = start;
            board_steps[LIST_LEN-1]  = steps;
        end
        // The rest of the list is already in order, so only the tail can move up.
        j = LIST_LEN - 1;
        while (j > 0 && ranks_above(board_steps[j], board_values[j],
                                    board_steps[j-1], board_values[j-1])) begin
            tv = board_values[j];
            ts = board_steps[j];
            board_values[j]   = board_values[j-1];
            board_steps[j]    = board_steps[j-1];
            board_values[j-1] = tv;
            board_steps[j-1]  = ts;
            j--;
        end
        r = '{result_kind: KIND_STEP, rank_index: 4'd0, entry_value: start, step_count: steps,
              admitted: adm, overflow: ovf, last_of_run: !fin};
        pending_results.push_back(r);
        if (fin) begin
            for (int i = 0; i < LIST_LEN; i++) begin
                r = '{result_kind: KIND_ENTRY, rank_index: 4'(i), entry_value: board_values[i],
                      step_count: board_steps[i], admitted: 1'b0, overflow: 1'b0,
                      last_of_run: (i == LIST_LEN - 1)};
                pending_results.push_back(r);
            end
        end
    endfunction

    // Drive one request and wait until the block takes it.
    task automatic send_request(input logic [31:0] value, input logic fin);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid       = 1'b1;
        i_start_value = value;
        i_final_item  = fin;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        rank_request(value, fin);
        sent++;
        if (fin) begin
            finals++;
        end
    endtask

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Compare every accepted result with the oldest one owed.
    always @(posedge i_clk) begin : check_result
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("result with none expected: kind %0d value %0h steps %0d",
                       o_result_kind, o_entry_value, o_step_count);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("result_kind", 32'(want.result_kind), 32'(o_result_kind));
                check_field("rank_index", 32'(want.rank_index), 32'(o_rank_index));
                check_field("entry_value", want.entry_value, o_entry_value);
                check_field("step_count", 32'(want.step_count), 32'(o_step_count));
                check_field("admitted", 32'(want.admitted), 32'(o_admitted));
                check_field("overflow", 32'(want.overflow), 32'(o_overflow));
                check_field("last_of_run", 32'(want.last_of_run), 32'(o_last_of_run));
            end
        end
    end

    // Result side: ready with random stalls of varying length.
    initial begin : sink_pacing
        int hold;
        i_ready = 1'b0;
        hold    = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                i_ready = 1'b0;
                hold--;
            end else begin
                i_ready = 1'b1;
                hold    = pick_gap();
            end
        end
    end

    // Stop a hung run.
    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("collatz_top_k_ranker: mismatch");
        $finish;
    end

    // Zero and one take no steps and never enter the list; two and three then do, and the list is read out.
    task automatic test_small_values();
        send_request(32'd0, 1'b0);
        send_request(32'd1, 1'b0);
        send_request(32'd2, 1'b0);
        send_request(32'd3, 1'b1);
    endtask

    // Widest value, a power of two and some long trajectories.
    task automatic test_extremes();
        send_request(32'hFFFF_FFFF, 1'b0);
        send_request(32'h8000_0000, 1'b0);
        send_request(32'd27, 1'b0);
        send_request(32'd63728127, 1'b0);
        send_request(32'd670617279, 1'b1);
    endtask

    // Equal step counts order by the larger number; a repeated number ties exactly.
    task automatic test_ties();
        send_request(32'd12, 1'b0);
        send_request(32'd13, 1'b0);
        send_request(32'd27, 1'b1);
    endtask

    // Fill the list with long runs, then offer a short one that must be turned away.
    task automatic test_list_full();
        send_request(32'd837799, 1'b0);
        send_request(32'd626331, 1'b0);
        send_request(32'd939497, 1'b0);
        send_request(32'd704623, 1'b0);
        send_request(32'd910107, 1'b0);
        send_request(32'd927003, 1'b0);
        send_request(32'd511935, 1'b0);
        send_request(32'd796095, 1'b0);
        send_request(32'd767903, 1'b0);
        send_request(32'd7, 1'b1);
    endtask

    // Random numbers of mixed magnitude, with the list read out now and then.
    task automatic test_random_requests();
        logic [31:0] v;
        int          pick;
        for (int i = 0; i < RANDOM_REQUESTS; i++) begin
            quiet = ((i / 64) % 3) == 2;
            pick  = $urandom_range(0, 9);
            if (pick < 6) begin
                v = $urandom();
            end else if (pick < 8) begin
                v = $urandom_range(0, 2000);
            end else begin
                v = $urandom() >> $urandom_range(1, 31);
            end
            send_request(v, $urandom_range(0, 11) == 0);
        end
        quiet = 1'b0;
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_start_value = '0;
        i_final_item  = 1'b0;
        for (int i = 0; i < LIST_LEN; i++) begin
            board_values[i] = '0;
            board_steps[i]  = '0;
        end
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_small_values();
        test_extremes();
        test_ties();
        test_list_full();
        test_random_requests();

        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d requests, %0d of them asking for the ranked list.", sent, finals);
        $display("Checked %0d results against the local list model.", results_seen);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("collatz_top_k_ranker: match");
        end else begin
            $display("collatz_top_k_ranker: mismatch");
        end
        $finish;
    end

endmodule

// File: collatz_top_k_ranker.f
rtl/ctk_pkg.sv
rtl/ctk_front.sv
rtl/ctk_collatz.sv
rtl/ctk_rank.sv
rtl/collatz_top_k_ranker.sv
tb/tb_top.sv
